>>> src/ftda_pkg.sv
// ----------------------------------------------------------------------------
// ftda_pkg: shared types and constants of the fixed-point to decimal text block
// Payload types of the three channels, the classified job passed from the
// front to the back, ASCII codes and constant tables for rounding and digits.
// ----------------------------------------------------------------------------
package ftda_pkg;

   // Q23.40 format
   localparam int FRAC_BITS = 40;
   localparam int INT_BITS = 24;
   localparam int ROUND_BITS = 36;

   // Digit counts and queue depth
   localparam int DIGIT_W = 4;
   localparam int INT_DIGITS = 7;
   localparam int QUEUE_DEPTH = 2;

   // Register reset value
   localparam logic signed [4:0] RESET_FRACTION_DIGITS = 5'sd2;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   // Magnitude thresholds for the automatic digit count
   localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
   localparam logic [63:0] TEN_Q = 64'd10 << FRAC_BITS;
   localparam logic [63:0] HUNDRED_Q = 64'd100 << FRAC_BITS;
   localparam logic [63:0] THOUSAND_Q = 64'd1000 << FRAC_BITS;
   localparam logic [63:0] TEN_THOUSAND_Q = 64'd10000 << FRAC_BITS;
   localparam logic [63:0] HUNDRED_THOUSAND_Q = 64'd100000 << FRAC_BITS;

   // Channel payloads
   typedef struct packed {
      logic signed [63:0] value;
   } ftda_req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } ftda_rsp_type;

   typedef struct packed {
      logic signed [4:0] fraction_digits;
   } ftda_csr_type;

   // Classified item from front to back
   typedef struct packed {
      logic               neg;
      logic [63:0]        mag;
      logic [DIGIT_W-1:0] digits;
   } ftda_job_type;

   // Half of one unit in the last printed place, as a Q.40 constant
   function automatic logic [ROUND_BITS-1:0] round_const(input logic [DIGIT_W-1:0] p);
      logic [ROUND_BITS-1:0] r;
      unique case (p)
         4'd1:    r = 36'd54975581389;
         4'd2:    r = 36'd5497558139;
         4'd3:    r = 36'd549755814;
         4'd4:    r = 36'd54975581;
         4'd5:    r = 36'd5497558;
         4'd6:    r = 36'd549756;
         4'd7:    r = 36'd54976;
         4'd8:    r = 36'd5498;
         4'd9:    r = 36'd550;
         4'd10:   r = 36'd55;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Powers of ten for the integer digit positions
   function automatic logic [INT_BITS-1:0] pow10(input logic [2:0] k);
      logic [INT_BITS-1:0] r;
      unique case (k)
         3'd0: r = 24'd1;
         3'd1: r = 24'd10;
         3'd2: r = 24'd100;
         3'd3: r = 24'd1000;
         3'd4: r = 24'd10000;
         3'd5: r = 24'd100000;
         3'd6: r = 24'd1000000;
         3'd7: r = 24'd10000000;
      endcase
      return r;
   endfunction

endpackage

>>> src/ftda_chan_if.sv
// ----------------------------------------------------------------------------
// ftda_chan_if: valid/ready channel
// One transfer moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ftda_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/ftda_front.sv
// ----------------------------------------------------------------------------
// ftda_front: accept and classify
// Holds the digit count register, takes the magnitude and sign of each value
// and settles its fraction digit count before it enters the queue.
// ----------------------------------------------------------------------------
module ftda_front #(
   parameter int MAX_FRACTION_DIGITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   ftda_chan_if.sink             req_if,
   ftda_chan_if.sink             csr_if,
   output logic                  job_valid,
   input  logic                  job_ready,
   output ftda_pkg::ftda_job_type job
);

   logic signed [4:0]               fraction_digits_ff;
   logic signed [4:0]               fraction_digits_in;
   logic [63:0]                     raw;
   logic [63:0]                     mag;
   logic                            neg;
   logic [ftda_pkg::DIGIT_W-1:0]    auto_digits;
   logic [ftda_pkg::DIGIT_W-1:0]    digits;

   // Take register writes at any time
   assign csr_if.ready = 1'b1;

   always_comb begin
      fraction_digits_in = fraction_digits_ff;
      if (csr_if.valid) begin
         fraction_digits_in = csr_if.data.fraction_digits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_digits_ff <= ftda_pkg::RESET_FRACTION_DIGITS;
      end else begin
         fraction_digits_ff <= fraction_digits_in;
      end
   end

   // Sign and magnitude
   assign raw = req_if.data.value;
   assign neg = raw[63];
   assign mag = neg ? (~raw + 64'd1) : raw;

   // Automatic count by magnitude
   always_comb begin
      priority if (mag < ftda_pkg::ONE_Q) begin
         auto_digits = 4'd6;
      end else if (mag < ftda_pkg::TEN_Q) begin
         auto_digits = 4'd5;
      end else if (mag < ftda_pkg::HUNDRED_Q) begin
         auto_digits = 4'd4;
      end else if (mag < ftda_pkg::THOUSAND_Q) begin
         auto_digits = 4'd3;
      end else if (mag < ftda_pkg::TEN_THOUSAND_Q) begin
         auto_digits = 4'd2;
      end else if (mag < ftda_pkg::HUNDRED_THOUSAND_Q) begin
         auto_digits = 4'd1;
      end else begin
         auto_digits = 4'd0;
      end
   end

   // Negative register selects automatic, large values saturate
   always_comb begin
      priority if (fraction_digits_ff[4]) begin
         digits = auto_digits;
      end else if (fraction_digits_ff[3:0] > ftda_pkg::DIGIT_W'(MAX_FRACTION_DIGITS)) begin
         digits = ftda_pkg::DIGIT_W'(MAX_FRACTION_DIGITS);
      end else begin
         digits = fraction_digits_ff[3:0];
      end
   end

   // Pass the classified item on
   assign job_valid    = req_if.valid;
   assign req_if.ready = job_ready;
   assign job.neg      = neg;
   assign job.mag      = mag;
   assign job.digits   = digits;

endmodule

>>> src/ftda_queue.sv
// ----------------------------------------------------------------------------
// ftda_queue: short job queue
// Decouples the front from the back so each side can stall on its own.
// ----------------------------------------------------------------------------
module ftda_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  ftda_pkg::ftda_job_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output ftda_pkg::ftda_job_type pop_data
);

   localparam int PTR_W = (ftda_pkg::QUEUE_DEPTH > 1) ? $clog2(ftda_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ftda_pkg::QUEUE_DEPTH + 1);

   ftda_pkg::ftda_job_type entry_ff [ftda_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(ftda_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ftda_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ftda_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/ftda_back.sv
// ----------------------------------------------------------------------------
// ftda_back: character sequencer
// Rounds the magnitude, then walks sign, integer digits, point and fraction
// digits, one character per cycle into the output register whenever it is free.
// ----------------------------------------------------------------------------
module ftda_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  ftda_pkg::ftda_job_type job,
   ftda_chan_if.source            rsp_if
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROUND = 3'd1;
   localparam logic [2:0] S_SIGN  = 3'd2;
   localparam logic [2:0] S_INT   = 3'd3;
   localparam logic [2:0] S_POINT = 3'd4;
   localparam logic [2:0] S_FRAC  = 3'd5;

   logic [2:0]                            state_ff, state_in;
   logic                                  neg_ff, neg_in;
   logic [63:0]                           mag_ff, mag_in;
   logic [ftda_pkg::DIGIT_W-1:0]          p_ff, p_in;
   logic [ftda_pkg::DIGIT_W-1:0]          cnt_ff, cnt_in;
   logic [ftda_pkg::INT_BITS-1:0]         ip_ff, ip_in;
   logic [ftda_pkg::FRAC_BITS-1:0]        fr_ff, fr_in;
   logic [2:0]                            pos_ff, pos_in;
   logic                                  seen_ff, seen_in;
   logic                                  out_valid_ff, out_valid_in;
   logic [7:0]                            out_char_ff, out_char_in;
   logic                                  out_last_ff, out_last_in;

   logic                                  adv;
   logic                                  emit;
   logic [7:0]                            emit_char;
   logic                                  emit_last;
   logic [63:0]                           rounded;
   logic [ftda_pkg::INT_BITS-1:0]         pw;
   logic [ftda_pkg::INT_BITS-1:0]         thr [10];
   logic [3:0]                            int_digit;
   logic [ftda_pkg::INT_BITS-1:0]         int_rem;
   logic [ftda_pkg::FRAC_BITS+3:0]        fr_x10;

   assign adv       = !out_valid_ff || rsp_if.ready;
   assign job_ready = (state_ff == S_IDLE);

   // Rounding add
   assign rounded = mag_ff + {28'd0, ftda_pkg::round_const(p_ff)};

   // Integer digit at the current position
   always_comb begin
      pw = ftda_pkg::pow10(pos_ff);
      thr[0] = '0;
      for (int d = 1; d < 10; d++) begin
         thr[d] = ftda_pkg::INT_BITS'(pw * ftda_pkg::INT_BITS'(d));
      end
      int_digit = 4'd0;
      for (int d = 1; d < 10; d++) begin
         if (ip_ff >= thr[d]) begin
            int_digit = 4'(d);
         end
      end
      int_rem = ip_ff - thr[int_digit];
   end

   // Next fraction digit: times ten
   assign fr_x10 = {1'b0, fr_ff, 3'b000} + {3'b000, fr_ff, 1'b0};

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      p_in      = p_ff;
      cnt_in    = cnt_ff;
      ip_in     = ip_ff;
      fr_in     = fr_ff;
      pos_in    = pos_ff;
      seen_in   = seen_ff;
      emit      = 1'b0;
      emit_char = ftda_pkg::CHAR_ZERO;
      emit_last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               neg_in   = job.neg;
               mag_in   = job.mag;
               p_in     = job.digits;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            ip_in    = rounded[63:ftda_pkg::FRAC_BITS];
            fr_in    = rounded[ftda_pkg::FRAC_BITS-1:0];
            pos_in   = 3'(ftda_pkg::INT_DIGITS - 1);
            seen_in  = 1'b0;
            state_in = neg_ff ? S_SIGN : S_INT;
         end
         S_SIGN: begin
            if (adv) begin
               emit      = 1'b1;
               emit_char = ftda_pkg::CHAR_MINUS;
               state_in  = S_INT;
            end
         end
         S_INT: begin
            if (int_digit == 4'd0 && !seen_ff && pos_ff != 3'd0) begin
               // drop a leading zero
               pos_in = pos_ff - 3'd1;
            end else if (adv) begin
               emit      = 1'b1;
               emit_char = ftda_pkg::CHAR_ZERO + {4'd0, int_digit};
               emit_last = (pos_ff == 3'd0) && (p_ff == '0);
               ip_in     = int_rem;
               seen_in   = 1'b1;
               if (pos_ff == 3'd0) begin
                  state_in = (p_ff == '0) ? S_IDLE : S_POINT;
               end else begin
                  pos_in = pos_ff - 3'd1;
               end
            end
         end
         S_POINT: begin
            if (adv) begin
               emit      = 1'b1;
               emit_char = ftda_pkg::CHAR_POINT;
               cnt_in    = p_ff;
               state_in  = S_FRAC;
            end
         end
         S_FRAC: begin
            if (adv) begin
               emit      = 1'b1;
               emit_char = ftda_pkg::CHAR_ZERO +
                           {4'd0, fr_x10[ftda_pkg::FRAC_BITS+3:ftda_pkg::FRAC_BITS]};
               emit_last = (cnt_ff == 4'd1);
               fr_in     = fr_x10[ftda_pkg::FRAC_BITS-1:0];
               cnt_in    = cnt_ff - 4'd1;
               if (cnt_ff == 4'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load on emit, clear on transfer
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = emit_char;
         out_last_in  = emit_last;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      p_ff        <= p_in;
      cnt_ff      <= cnt_in;
      ip_ff       <= ip_in;
      fr_ff       <= fr_in;
      pos_ff      <= pos_in;
      seen_ff     <= seen_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.data.char_code = out_char_ff;
   assign rsp_if.data.last      = out_last_ff;

   // Fraction phase always has digits left
   a_frac_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FRAC |-> cnt_ff != '0)
      else $error("fraction phase with no digits left");

   // Integer remainder fits below the current position
   a_int_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INT |-> ip_ff < ftda_pkg::pow10(3'(pos_ff + 3'd1)))
      else $error("integer remainder exceeds digit position");

   // Final character ends the item
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      emit && emit_last |=> state_ff == S_IDLE)
      else $error("sequencer busy after final character");

endmodule

>>> src/fixed_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii: Q23.40 to decimal ASCII text
// Each accepted value is printed as '-' when negative, integer digits, and
// '.' and fraction digits when the count is not zero, one character per
// transfer with a flag on the last one. The fraction digit count comes from
// a register of -16 to 15: a negative value selects an automatic count
// chosen by magnitude and values above 10 saturate; the value is rounded at
// that place before printing when the count is not zero. The front passes a
// value combinationally into a two-entry queue; the back loads a value, does
// the rounding add, then emits one character per cycle while the output is
// not stalled, skipping suppressed leading integer zero positions. A value of
// 1 to 19 characters leaves through the single character output register.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii #(
   parameter int MAX_FRACTION_DIGITS = 10
) (
   input  logic      clock,
   input  logic      reset,
   ftda_chan_if.sink   req_if,
   ftda_chan_if.sink   csr_if,
   ftda_chan_if.source rsp_if
);

   logic                   front_valid;
   logic                   front_ready;
   ftda_pkg::ftda_job_type front_job;
   logic                   back_valid;
   logic                   back_ready;
   ftda_pkg::ftda_job_type back_job;

   // Accept and classify
   ftda_front #(
      .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_if    (csr_if),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job       (front_job)
   );

   // Hold classified jobs
   ftda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   // Emit characters
   ftda_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job       (back_job),
      .rsp_if    (rsp_if)
   );

endmodule

>>> verif/ftda_checker.sv
// ----------------------------------------------------------------------------
// ftda_checker: scoreboard for the fixed-point to decimal text block
// Watches the request, register and character channels. Every accepted value
// is formatted here into the characters it must produce. Those characters are
// queued and compared in order with each character transfer.
// ----------------------------------------------------------------------------
module ftda_checker #(
   parameter int MAX_FRACTION_DIGITS = 10
) (
   input  logic clock,
   input  logic reset,
   ftda_chan_if req_ch,
   ftda_chan_if csr_ch,
   ftda_chan_if rsp_ch,
   output int   mismatch_count,
   output int   chars_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Characters still owed by the block, oldest first
   ftda_pkg::ftda_rsp_type text_chars[$];

   // Shadow of the fraction digit register
   logic signed [4:0] digits_setting;

   // Format one Q23.40 value and queue its characters
   function automatic void format_value(input logic [63:0] value,
                                        input logic signed [4:0] setting);
      logic [63:0]            mag;
      logic [63:0]            ip;
      logic [63:0]            fr;
      logic [63:0]            pw;
      logic [63:0]            bump;
      logic [63:0]            d;
      logic [7:0]             text[0:23];
      logic [7:0]             rev[0:11];
      ftda_pkg::ftda_rsp_type ch;
      int                     p;
      int                     n;
      int                     nr;
      int                     i;
      n = 0;
      nr = 0;
      mag = value[63] ? (~value + 64'd1) : value;
      if (value[63]) begin
         text[n] = ftda_pkg::CHAR_MINUS;
         n++;
      end

      // Resolve the digit count: saturate high, pick by magnitude when negative
      p = setting;
      if (p > MAX_FRACTION_DIGITS) p = MAX_FRACTION_DIGITS;
      if (p < 0) begin
         if (mag < ftda_pkg::ONE_Q) p = 6;
         else if (mag < ftda_pkg::TEN_Q) p = 5;
         else if (mag < ftda_pkg::HUNDRED_Q) p = 4;
         else if (mag < ftda_pkg::THOUSAND_Q) p = 3;
         else if (mag < ftda_pkg::TEN_THOUSAND_Q) p = 2;
         else if (mag < ftda_pkg::HUNDRED_THOUSAND_Q) p = 1;
         else p = 0;
      end

      // Add half a unit of the last printed place, rounded to Q.40
      if (p > 0) begin
         pw = 64'd1;
         for (i = 0; i <= p; i++) pw = pw * 64'd10;
         bump = ((64'd5 << ftda_pkg::FRAC_BITS) + pw / 64'd2) / pw;
         mag = mag + bump;
      end

      ip = mag >> ftda_pkg::FRAC_BITS;
      fr = mag & ((64'd1 << ftda_pkg::FRAC_BITS) - 64'd1);

      // Integer digits, most significant first
      if (ip == 64'd0) begin
         text[n] = ftda_pkg::CHAR_ZERO;
         n++;
      end else begin
         while (ip != 64'd0 && nr < 12) begin
            d = ip % 64'd10;
            rev[nr] = ftda_pkg::CHAR_ZERO + d[7:0];
            nr++;
            ip = ip / 64'd10;
         end
         while (nr > 0) begin
            nr--;
            text[n] = rev[nr];
            n++;
         end
      end

      // Point and exact fraction digits
      if (p > 0) begin
         text[n] = ftda_pkg::CHAR_POINT;
         n++;
         for (i = 0; i < p; i++) begin
            fr = fr * 64'd10;
            d = fr >> ftda_pkg::FRAC_BITS;
            text[n] = ftda_pkg::CHAR_ZERO + d[7:0];
            n++;
            fr = fr & ((64'd1 << ftda_pkg::FRAC_BITS) - 64'd1);
         end
      end

      for (i = 0; i < n; i++) begin
         ch.char_code = text[i];
         ch.last = (i == n - 1);
         text_chars.push_back(ch);
      end
   endfunction

   // Track register writes, format accepted values, compare each character
   always @(posedge clock) begin
      ftda_pkg::ftda_req_type item;
      ftda_pkg::ftda_csr_type wr;
      ftda_pkg::ftda_rsp_type seen;
      ftda_pkg::ftda_rsp_type want;
      if (reset) begin
         text_chars.delete();
         digits_setting = ftda_pkg::RESET_FRACTION_DIGITS;
         mismatch_count = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            wr = csr_ch.data;
            digits_setting = wr.fraction_digits;
         end
         if (req_ch.valid && req_ch.ready) begin
            item = req_ch.data;
            format_value(item.value, digits_setting);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = rsp_ch.data;
            if (text_chars.size() == 0) begin
               $error("unexpected character transfer: char_code %h last %b",
                      seen.char_code, seen.last);
               mismatch_count++;
            end else begin
               want = text_chars.pop_front();
               if (seen.char_code !== want.char_code) begin
                  $error("char_code expected %h actual %h", want.char_code, seen.char_code);
                  mismatch_count++;
               end
               if (seen.last !== want.last) begin
                  $error("last expected %b actual %b", want.last, seen.last);
                  mismatch_count++;
               end
            end
         end
      end
      chars_pending = text_chars.size();
   end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the fixed-point to decimal text block
// Drives Q23.40 values in random bursts and gaps, rewrites the fraction digit
// register between phases and stalls the character channel on its own
// pattern, with two long hold-offs. The checker does the prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_SPARSE,
      STALL_BLOCK
   } stall_mode_type;

   localparam int RANDOM_ITEMS = 256;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES = 30;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   chars_pending;
   int   hold_off_seq;
   int   burst_left;

   ftda_chan_if #(.payload_type(ftda_pkg::ftda_req_type)) req_ch ();
   ftda_chan_if #(.payload_type(ftda_pkg::ftda_csr_type)) csr_ch ();
   ftda_chan_if #(.payload_type(ftda_pkg::ftda_rsp_type)) rsp_ch ();

   fixed_to_decimal_ascii #(.MAX_FRACTION_DIGITS(10)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .csr_if (csr_ch),
      .rsp_if (rsp_ch)
   );

   ftda_checker #(.MAX_FRACTION_DIGITS(10)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .csr_ch         (csr_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   // Free-running clock, 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up after a generous fixed time
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Offer one value, hold it until the transfer, then maybe open a gap
   task automatic send_value(input logic [63:0] v);
      int gap;
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.data.value <= v;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Drop valid and wait until every queued character has come out
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (chars_pending != 0) @(negedge clock);
   endtask

   // Write the fraction digit register while the block is idle
   task automatic write_digits(input logic signed [4:0] setting);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data.fraction_digits <= setting;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Random value: full range, small numbers, rounding edges, thresholds, extremes
   function automatic logic [63:0] pick_value();
      logic [63:0]  m;
      logic [63:0]  pw;
      logic [63:0]  d;
      logic [63:0]  ipart;
      logic [39:0]  f;
      logic [127:0] wide;
      int           kind;
      int           p;
      int           i;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         m = {$urandom, $urandom};
         return m;
      end
      if (kind < 55) begin
         ipart = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 20) : $urandom_range(0, 999999);
         f = 40'({$urandom, $urandom});
         m = (ipart << ftda_pkg::FRAC_BITS) | {24'd0, f};
      end else if (kind < 70) begin
         // just around a printed half digit, where rounding flips
         p = $urandom_range(1, 10);
         pw = 64'd1;
         for (i = 0; i <= p; i++) pw = pw * 64'd10;
         d = {$urandom, $urandom};
         d = d % (pw / 64'd10);
         wide = ({64'd0, d} * 128'd10 + 128'd5) << ftda_pkg::FRAC_BITS;
         wide = wide / {64'd0, pw};
         ipart = $urandom_range(0, 99999);
         m = (ipart << ftda_pkg::FRAC_BITS) + wide[63:0] + $urandom_range(0, 4) - 64'd2;
      end else if (kind < 85) begin
         // near a power of ten, where the automatic count changes
         case ($urandom_range(0, 5))
            0: m = ftda_pkg::ONE_Q;
            1: m = ftda_pkg::TEN_Q;
            2: m = ftda_pkg::HUNDRED_Q;
            3: m = ftda_pkg::THOUSAND_Q;
            4: m = ftda_pkg::TEN_THOUSAND_Q;
            default: m = ftda_pkg::HUNDRED_THOUSAND_Q;
         endcase
         if ($urandom_range(0, 1) == 1) m = m - $urandom_range(0, 1 << 20);
         else m = m + $urandom_range(0, 3);
      end else begin
         case ($urandom_range(0, 2))
            0: m = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
            1: m = 64'h8000_0000_0000_0000 + $urandom_range(0, 3);
            default: m = $urandom_range(0, 1000);
         endcase
      end
      if ($urandom_range(0, 1) == 1) m = ~m + 64'd1;
      return m;
   endfunction

   // Character channel: stall in random stretches, hold off on request
   initial begin
      stall_mode_type mode;
      int             left;
      int             hold;
      int             seen_seq;
      int             r;
      rsp_ch.ready = 1'b0;
      left = 0;
      hold = 0;
      seen_seq = 0;
      mode = STALL_NONE;
      @(negedge clock);
      forever begin
         if (hold_off_seq != seen_seq) begin
            seen_seq = hold_off_seq;
            hold = HOLD_OFF_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (left == 0) begin
               r = $urandom_range(0, 5);
               mode = (r < 2) ? STALL_NONE : stall_mode_type'(r - 2);
               left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
               STALL_NONE:   rsp_ch.ready <= 1'b1;
               STALL_HALF:   rsp_ch.ready <= ($urandom_range(0, 1) == 1);
               STALL_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               STALL_BLOCK:  rsp_ch.ready <= (left % 16 == 0);
               default:      rsp_ch.ready <= 1'b1;
            endcase
         end
         @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      logic signed [4:0] setting;
      int                sent;
      int                phase;
      int                n;
      int                k;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      hold_off_seq = 0;
      burst_left = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset setting of two digits: zero, tiny, negative to zero, extremes, half cent
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'hFFFF_FFFF_FFFF_FFFF);
      send_value(64'h7FFF_FFFF_FFFF_FFFF);
      send_value(64'h8000_0000_0000_0000);
      send_value((64'd5 << ftda_pkg::FRAC_BITS) / 64'd1000);
      drain();

      // Automatic count across every magnitude threshold
      write_digits(-5'sd1);
      send_value(ftda_pkg::ONE_Q - 64'd1);
      send_value(ftda_pkg::ONE_Q);
      send_value(ftda_pkg::TEN_Q - 64'd1);
      send_value(ftda_pkg::HUNDRED_Q);
      send_value(ftda_pkg::THOUSAND_Q - 64'd1);
      send_value(ftda_pkg::TEN_THOUSAND_Q);
      send_value(ftda_pkg::HUNDRED_THOUSAND_Q - 64'd1);
      send_value(ftda_pkg::HUNDRED_THOUSAND_Q);
      send_value(~ftda_pkg::ONE_Q + 64'd1);
      drain();

      // Widest text: most negative value with ten digits
      write_digits(5'sd10);
      send_value(64'h8000_0000_0000_0000);
      send_value(64'h7FFF_FFFF_FFFF_FFFF);
      send_value(64'd1);
      drain();

      // No fraction digits: truncate
      write_digits(5'sd0);
      send_value(ftda_pkg::ONE_Q - 64'd1);
      send_value(~(ftda_pkg::ONE_Q >> 1) + 64'd1);
      send_value(64'h8000_0000_0000_0000);
      drain();

      // Counts above the maximum saturate
      write_digits(5'sd15);
      send_value((64'd123456 << ftda_pkg::FRAC_BITS) / 64'd1000);
      send_value(64'hFFFF_FFFF_FFFF_FFFF);
      drain();

      // Most negative setting still selects the automatic count
      write_digits(-5'sd16);
      send_value(ftda_pkg::TEN_Q + 64'd12345);
      drain();

      // Random phases, each under its own register setting
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: setting = -5'sd1;
            1: setting = 5'sd0;
            2: setting = 5'sd10;
            3: setting = 5'sd15;
            4: setting = -5'sd16;
            5: setting = 5'sd2;
            default: setting = 5'($urandom_range(0, 31));
         endcase
         write_digits(setting);
         n = $urandom_range(15, 40);
         for (k = 0; k < n && sent < RANDOM_ITEMS; k++) begin
            send_value(pick_value());
            sent++;
            if ((phase == 0 || phase == 4) && k == 3) hold_off_seq++;
         end
         drain();
         phase++;
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
